/* src/esa_pkg.sv */
package esa_pkg;

	// Detent lockout defaults and counter width (the lockout range is 1 to 15).
	localparam int unsigned LockoutTicksDefault = 10;
	localparam int unsigned LockW               = 4;

	// Setpoint width and saturation limits.
	localparam int unsigned ValueW   = 16;
	localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};
	localparam logic [ValueW-1:0] ValueMin = '0;

	// Top values of the cycling selectors.
	localparam logic [2:0] PrescaleTop = 3'd4;
	localparam logic [1:0] StepTop     = 2'd3;
	localparam logic [1:0] ModeTop     = 2'd2;

	// Step select codes.
	localparam logic [1:0] StepOne      = 2'd0;
	localparam logic [1:0] StepTen      = 2'd1;
	localparam logic [1:0] StepHundred  = 2'd2;
	localparam logic [1:0] StepThousand = 2'd3;

	// Selector state shared between the button logic and the top level.
	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] step;
		logic [2:0] prescale;
	} sel_t;

	// Detent tracking state.
	typedef struct packed {
		logic            active;
		logic            applied;
		logic [LockW-1:0] count;
	} det_t;

	// Input transaction, line_a in the lowest bit.
	typedef struct packed {
		logic mode_press;
		logic step_press;
		logic prescale_press;
		logic line_b;
		logic line_a;
	} in_t;

	// Result transaction, compare_value in the lowest bits.
	typedef struct packed {
		logic              value_changed;
		logic [1:0]        mode_sel;
		logic [1:0]        step_sel;
		logic [2:0]        prescale_sel;
		logic [ValueW-1:0] compare_value;
	} out_t;

	// Step size for each step select code.
	function automatic logic [ValueW-1:0] step_amount(input logic [1:0] idx);
		logic [ValueW-1:0] amt;
		unique case (idx)
			StepOne:      amt = ValueW'(1);
			StepTen:      amt = ValueW'(10);
			StepHundred:  amt = ValueW'(100);
			StepThousand: amt = ValueW'(1000);
			default:      amt = ValueW'(1);
		endcase
		return amt;
	endfunction

endpackage

/* src/esa_select.sv */
module esa_select (
	input  esa_pkg::sel_t sel_cur,
	input  logic          prescale_press,
	input  logic          step_press,
	input  logic          mode_press,
	output esa_pkg::sel_t sel_next
);

	// Each press advances its selector by one and wraps past the top value.
	always_comb begin
		sel_next = sel_cur;
		if (prescale_press) begin
			sel_next.prescale = (sel_cur.prescale >= esa_pkg::PrescaleTop) ? 3'd0
				: sel_cur.prescale + 3'd1;
		end
		if (step_press) begin
			sel_next.step = (sel_cur.step == esa_pkg::StepTop) ? 2'd0 : sel_cur.step + 2'd1;
		end
		if (mode_press) begin
			sel_next.mode = (sel_cur.mode >= esa_pkg::ModeTop) ? 2'd0 : sel_cur.mode + 2'd1;
		end
	end

endmodule

/* src/esa_detent.sv */
module esa_detent #(
	parameter int unsigned LOCKOUT_TICKS = esa_pkg::LockoutTicksDefault
) (
	input  logic                       line_a,
	input  logic                       line_b,
	input  logic [1:0]                 step_sel,
	input  logic [esa_pkg::ValueW-1:0] value_cur,
	input  esa_pkg::det_t              det_cur,
	output logic [esa_pkg::ValueW-1:0] value_next,
	output esa_pkg::det_t              det_next,
	output logic                       changed
);

	localparam logic [esa_pkg::LockW-1:0] LockLoad = esa_pkg::LockW'(LOCKOUT_TICKS);

	logic [esa_pkg::ValueW-1:0] step;
	logic [esa_pkg::ValueW:0]   sum;
	logic [esa_pkg::ValueW:0]   diff;
	logic [esa_pkg::ValueW-1:0] stepped;
	logic                       both_high;
	logic [esa_pkg::LockW-1:0]  count_work;

	// Saturating add or subtract of the selected step; line A picks the direction.
	always_comb begin
		step    = esa_pkg::step_amount(step_sel);
		sum     = {1'b0, value_cur} + {1'b0, step};
		diff    = {1'b0, value_cur} - {1'b0, step};
		if (line_a) begin
			stepped = sum[esa_pkg::ValueW] ? esa_pkg::ValueMax : sum[esa_pkg::ValueW-1:0];
		end else begin
			stepped = diff[esa_pkg::ValueW] ? esa_pkg::ValueMin : diff[esa_pkg::ValueW-1:0];
		end
	end

	// One step per detent, then count both-high ticks until the lockout ends it.
	always_comb begin
		both_high  = line_a & line_b;
		value_next = value_cur;
		det_next   = det_cur;
		changed    = 1'b0;
		count_work = det_cur.count;
		if (!both_high || det_cur.active) begin
			if (!det_cur.applied) begin
				det_next.active  = 1'b1;
				det_next.applied = 1'b1;
				value_next       = stepped;
				count_work       = LockLoad;
				changed          = 1'b1;
			end
			if (both_high) begin
				if (count_work != '0) begin
					det_next.count = count_work - 1'b1;
					if (count_work == esa_pkg::LockW'(1)) begin
						det_next.active  = 1'b0;
						det_next.applied = 1'b0;
					end
				end else begin
					det_next.count   = count_work;
					det_next.active  = 1'b0;
					det_next.applied = 1'b0;
				end
			end else begin
				det_next.count = count_work;
			end
		end
	end

endmodule

/* src/encoder_setpoint_adjuster_top.sv */
// Channel  Dir  Handshake             Payload
// s        in   s_tvalid / s_tready   s_tdata: line_a, line_b, prescale_press, step_press,
//                                     mode_press, zero fill
// m        out  m_tvalid / m_tready   m_tdata: compare_value, prescale_sel, step_sel,
//                                     mode_sel, value_changed
//
// One transaction per clock sustained while m_tready stays high. An accepted input
// transaction passes the input register, the tick logic and then the result register.
// The setpoint, selectors and detent state update in the same cycle the result is loaded.
// A stalled result holds the result register; the input register still takes one more
// transaction and s_tready follows m_tready combinationally when both stages are full.
// Reset (arst_n low) clears the setpoint, selectors and detent state and empties both stages.
module encoder_setpoint_adjuster_top #(
	parameter int unsigned LOCKOUT_TICKS = esa_pkg::LockoutTicksDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // line_a, line_b, prescale_press, step_press, mode_press, 0
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // compare_value, prescale_sel, step_sel, mode_sel,
	                               // value_changed
);

	localparam int unsigned InW = $bits(esa_pkg::in_t);

	esa_pkg::in_t  item_s1;
	logic          valid_s1;
	esa_pkg::out_t result_s2;
	logic          valid_s2;

	logic [esa_pkg::ValueW-1:0] value_q;
	esa_pkg::sel_t              sel_q;
	esa_pkg::det_t              det_q;

	esa_pkg::sel_t              sel_next;
	esa_pkg::det_t              det_next;
	logic [esa_pkg::ValueW-1:0] value_next;
	logic                       changed;
	logic                       advance;

	// Pipeline flow control.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= esa_pkg::in_t'(s_tdata[InW-1:0]);
		end
	end

	// Button handling comes first so the encoder step sees the new step select.
	esa_select u_select (
		.sel_cur        (sel_q),
		.prescale_press (item_s1.prescale_press),
		.step_press     (item_s1.step_press),
		.mode_press     (item_s1.mode_press),
		.sel_next       (sel_next)
	);

	esa_detent #(
		.LOCKOUT_TICKS (LOCKOUT_TICKS)
	) u_detent (
		.line_a     (item_s1.line_a),
		.line_b     (item_s1.line_b),
		.step_sel   (sel_next.step),
		.value_cur  (value_q),
		.det_cur    (det_q),
		.value_next (value_next),
		.det_next   (det_next),
		.changed    (changed)
	);

	// Block state, updated when a tick moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			sel_q   <= '0;
			det_q   <= '0;
		end else if (advance) begin
			value_q <= value_next;
			sel_q   <= sel_next;
			det_q   <= det_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.compare_value <= value_next;
			result_s2.prescale_sel  <= sel_next.prescale;
			result_s2.step_sel      <= sel_next.step;
			result_s2.mode_sel      <= sel_next.mode;
			result_s2.value_changed <= changed;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

`ifndef SYNTH
	// A detent in progress always has its step applied.
	assert property (@(posedge clk) disable iff (!arst_n) det_q.active |-> det_q.applied)
		else $error("detent active without applied step");

	// A reported step leaves the detent marked as applied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && changed) |=> (det_q.applied && det_q.active))
		else $error("step reported but detent not recorded");

	// Selectors never leave their ranges.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q.prescale <= esa_pkg::PrescaleTop) && (sel_q.mode <= esa_pkg::ModeTop))
		else $error("selector out of range");

	// The block state changes only when a tick is evaluated.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(value_q) && $stable(sel_q) && $stable(det_q)))
		else $error("state changed without a tick");
`endif

endmodule
